// ===== rtl/lss_pkg.sv =====
// Package for the LIFO stack with search: command and status codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package lss_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned POS_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_DISPLAY = 3'd3,
    CMD_SEARCH  = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_e;

  // what the output register is loaded with
  typedef enum logic [2:0] {
    OUT_PUSH_OK,
    OUT_OVERFLOW,
    OUT_EMPTY,
    OUT_TOP,
    OUT_DISP,
    OUT_FOUND,
    OUT_NOTFOUND
  } out_sel_e;

  typedef struct packed {
    logic     cap_val;
    logic     push_wr;
    logic     fill_dec;
    logic     rd_top;
    logic     rd_next;
    logic     out_ld;
    out_sel_e out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic idx_zero;
    logic out_last;
  } dp_stat_t;

endpackage

// ===== rtl/lss_in_if.sv =====
// Input channel of the LIFO stack: valid/ready handshake with command and value.
// Depends on lss_pkg.
interface lss_in_if;
  logic                                valid;
  logic                                ready;
  logic        [lss_pkg::CMD_W-1:0]    cmd;
  logic signed [lss_pkg::DATA_W-1:0]   value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== rtl/lss_out_if.sv =====
// Result channel of the LIFO stack: valid/ready handshake with status, data,
// position and last mark. Depends on lss_pkg.
interface lss_out_if;
  logic                                valid;
  logic                                ready;
  logic        [lss_pkg::STAT_W-1:0]   status;
  logic signed [lss_pkg::DATA_W-1:0]   data;
  logic        [lss_pkg::POS_W-1:0]    position;
  logic                                last;

  modport source (output valid, output status, output data, output position,
                  output last, input ready);
  modport sink   (input valid, input status, input data, input position,
                  input last, output ready);
endinterface

// ===== rtl/lss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lss_dp.sv =====
// Datapath of the LIFO stack: fill count, walk index, stack RAM, search
// compare and the result register. Depends on lss_pkg and lss_ram.
module lss_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lss_pkg::dp_cmd_t                   cmd_i,
  output lss_pkg::dp_stat_t                  stat_o,
  input  logic signed [lss_pkg::DATA_W-1:0]  value_i,
  output logic        [lss_pkg::STAT_W-1:0]  status_o,
  output logic signed [lss_pkg::DATA_W-1:0]  data_o,
  output logic        [lss_pkg::POS_W-1:0]   position_o,
  output logic                               last_o
);
  import lss_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);

  logic [FW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [DATA_W-1:0] value_q;
  logic [FW-1:0]     fill_m1;
  logic [AW-1:0]     top_addr, next_addr, raddr;
  logic [DATA_W-1:0] rdata;
  logic [AW:0]       pos_w;

  logic [STAT_W-1:0] status_q, status_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [POS_W-1:0]  position_q, position_d;
  logic              last_q, last_d;

  assign fill_m1   = fill_q - FW'(1);
  assign top_addr  = fill_m1[AW-1:0];
  assign next_addr = idx_q - AW'(1);
  assign raddr     = cmd_i.rd_top ? top_addr : next_addr;

  lss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push_wr),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (value_i),
    .re_i    (cmd_i.rd_top | cmd_i.rd_next),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.push_wr) begin
      fill_d = fill_q + FW'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = fill_m1;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.rd_top) begin
      idx_d = top_addr;
    end else if (cmd_i.rd_next) begin
      idx_d = next_addr;
    end
  end

  assign pos_w = {1'b0, idx_q} + (AW + 1)'(1);

  always_comb begin
    status_d   = status_q;
    data_d     = data_q;
    position_d = position_q;
    last_d     = last_q;
    if (cmd_i.out_ld) begin
      status_d   = STAT_OK;
      data_d     = '0;
      position_d = '0;
      last_d     = 1'b1;
      unique case (cmd_i.out_sel)
        OUT_PUSH_OK:  status_d = STAT_OK;
        OUT_OVERFLOW: status_d = STAT_OVERFLOW;
        OUT_EMPTY:    status_d = STAT_EMPTY;
        OUT_TOP:      data_d   = rdata;
        OUT_DISP: begin
          data_d = rdata;
          last_d = (idx_q == '0);
        end
        OUT_FOUND:    position_d = POS_W'(pos_w);
        OUT_NOTFOUND: status_d   = STAT_NOTFOUND;
        default:      status_d   = STAT_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    status_q   <= status_d;
    data_q     <= data_d;
    position_q <= position_d;
    last_q     <= last_d;
    if (cmd_i.cap_val) begin
      value_q <= value_i;
    end
  end

  assign stat_o.full     = (fill_q == FW'(DEPTH));
  assign stat_o.empty    = (fill_q == '0);
  assign stat_o.match    = (rdata == value_q);
  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.out_last = last_q;

  assign status_o   = status_q;
  assign data_o     = data_q;
  assign position_o = position_q;
  assign last_o     = last_q;

endmodule

// ===== rtl/lss_ctrl.sv =====
// Controller of the LIFO stack: decodes commands, sequences RAM reads for
// pop, peek, display and search, and runs both handshakes. Depends on lss_pkg.
module lss_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [lss_pkg::CMD_W-1:0]  in_cmd_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lss_pkg::dp_cmd_t           dp_cmd_o,
  input  lss_pkg::dp_stat_t          dp_stat_i
);
  import lss_pkg::*;

  state_e state_q, state_d;
  cmd_e   op_q, op_d;
  cmd_e   in_op;
  logic   in_acc, out_acc;

  assign in_op   = cmd_e'(in_cmd_i);
  assign in_acc  = in_valid_i && (state_q == ST_IDLE);
  assign out_acc = out_ready_i && (state_q == ST_OUT);

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d = in_op;
          unique case (in_op)
            CMD_PUSH: state_d = ST_OUT;
            CMD_POP, CMD_PEEK, CMD_DISPLAY, CMD_SEARCH:
              state_d = dp_stat_i.empty ? ST_OUT : ST_READ;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        if (op_q != CMD_SEARCH || dp_stat_i.match || dp_stat_i.idx_zero) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          state_d = dp_stat_i.out_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    dp_cmd_o = '{default: '0, out_sel: OUT_PUSH_OK};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          dp_cmd_o.cap_val = 1'b1;
          unique case (in_op)
            CMD_PUSH: begin
              dp_cmd_o.out_ld = 1'b1;
              if (dp_stat_i.full) begin
                dp_cmd_o.out_sel = OUT_OVERFLOW;
              end else begin
                dp_cmd_o.push_wr = 1'b1;
                dp_cmd_o.out_sel = OUT_PUSH_OK;
              end
            end
            CMD_POP, CMD_PEEK, CMD_DISPLAY, CMD_SEARCH: begin
              if (dp_stat_i.empty) begin
                dp_cmd_o.out_ld  = 1'b1;
                dp_cmd_o.out_sel = OUT_EMPTY;
              end else begin
                dp_cmd_o.rd_top   = 1'b1;
                dp_cmd_o.fill_dec = (in_op == CMD_POP);
              end
            end
            default: dp_cmd_o.cap_val = 1'b0;
          endcase
        end
      end
      ST_READ: begin
        priority if (op_q == CMD_SEARCH) begin
          if (dp_stat_i.match) begin
            dp_cmd_o.out_ld  = 1'b1;
            dp_cmd_o.out_sel = OUT_FOUND;
          end else if (dp_stat_i.idx_zero) begin
            dp_cmd_o.out_ld  = 1'b1;
            dp_cmd_o.out_sel = OUT_NOTFOUND;
          end else begin
            dp_cmd_o.rd_next = 1'b1;
          end
        end else if (op_q == CMD_DISPLAY) begin
          dp_cmd_o.out_ld  = 1'b1;
          dp_cmd_o.out_sel = OUT_DISP;
        end else begin
          dp_cmd_o.out_ld  = 1'b1;
          dp_cmd_o.out_sel = OUT_TOP;
        end
      end
      ST_OUT: begin
        // display walks on to the next entry once this beat is taken
        if (out_acc && !dp_stat_i.out_last) begin
          dp_cmd_o.rd_next = 1'b1;
        end
      end
      default: dp_cmd_o.out_sel = OUT_PUSH_OK;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= CMD_PUSH;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// ===== rtl/lifo_stack_with_search.sv =====
// LIFO stack with search: bounded stack of signed 32-bit words, DEPTH deep.
// Top level joining the controller and the datapath.
// Depends on lss_pkg, lss_in_if, lss_out_if, lss_ctrl, lss_dp.
//
// Channels: in_i carries cmd (push, pop, peek, display, search) and value;
// out_o carries status, data, position and last, one beat per result, with
// last set on the final beat of each command. Unused command codes are
// accepted and give no result.
// One command is in flight at a time; in_i.ready is high only when idle.
// Push gives its result in the cycle after acceptance. Pop and peek read
// the stack RAM (registered read) and give their result from the output
// register after that read. Display gives one beat per stored word, each
// read and then loaded into the output register; search compares one stored
// word per cycle from the top down until a match or the bottom word.
// Reset empties the stack at once; no clearing pass is needed.
// When the receiver stalls, the result is held in the output register and
// no new command is taken until the last beat has gone.
module lifo_stack_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  lss_in_if.sink    in_i,
  lss_out_if.source out_o
);
  import lss_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  lss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_cmd_i    (in_i.cmd),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .dp_cmd_o    (dp_cmd),
    .dp_stat_i   (dp_stat)
  );

  lss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .value_i    (in_i.value),
    .status_o   (out_o.status),
    .data_o     (out_o.data),
    .position_o (out_o.position),
    .last_o     (out_o.last)
  );

endmodule

// ===== tb/lifo_stack_with_search_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lifo_stack_with_search: a shadow stack predicts every
// result beat, and a monitor compares the beats while both channels idle at random.
// Depends on lss_pkg, lss_in_if, lss_out_if and the RTL of the block.
module lifo_stack_with_search_test;
  import lss_pkg::*;

  localparam int unsigned STACK_DEPTH  = 16;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned SETTLE_TIME  = 40;
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  data;
    logic        [POS_W-1:0]   position;
    logic                      last;
  } stack_result_t;

  logic clk;
  logic rst_n;

  lss_in_if  cmd_ch ();
  lss_out_if result_ch ();

  lifo_stack_with_search #(
    .DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cmd_ch),
    .out_o (result_ch)
  );

  // shadow copy of the stack contents
  logic signed [DATA_W-1:0] shadow_words [STACK_DEPTH];
  int unsigned              shadow_fill;

  stack_result_t pending_results [$];
  int unsigned   mismatches;
  int unsigned   cycle_count;
  int unsigned   burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void note_result(status_e st, logic signed [DATA_W-1:0] word,
                                      int unsigned pos, logic is_last);
    pending_results.push_back(stack_result_t'{status: st, data: word,
                                              position: POS_W'(pos), last: is_last});
  endfunction

  // Works out the beats that one accepted command produces and updates the shadow stack.
  function automatic void apply_stack_command(logic [CMD_W-1:0] op,
                                              logic signed [DATA_W-1:0] word);
    int unsigned idx;
    bit          found;
    found = 1'b0;
    case (op)
      CMD_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          note_result(STAT_OVERFLOW, '0, 0, 1'b1);
        end else begin
          shadow_words[shadow_fill] = word;
          shadow_fill++;
          note_result(STAT_OK, '0, 0, 1'b1);
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (shadow_fill == 0) begin
          note_result(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          note_result(STAT_OK, shadow_words[shadow_fill-1], 0, 1'b1);
          if (op == CMD_POP) shadow_fill--;
        end
      end
      CMD_DISPLAY: begin
        if (shadow_fill == 0) begin
          note_result(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          for (idx = shadow_fill; idx > 0; idx--)
            note_result(STAT_OK, shadow_words[idx-1], 0, idx == 1);
        end
      end
      CMD_SEARCH: begin
        if (shadow_fill == 0) begin
          note_result(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          // topmost match wins
          for (idx = shadow_fill; idx > 0 && !found; idx--) begin
            if (shadow_words[idx-1] == word) begin
              note_result(STAT_OK, '0, idx, 1'b1);
              found = 1'b1;
            end
          end
          if (!found) note_result(STAT_NOTFOUND, '0, 0, 1'b1);
        end
      end
      default: ; // unused codes: no beat, no state change
    endcase
  endfunction

  // Sends one command beat, idling between bursts, and predicts on acceptance.
  task automatic send_stack_beat(logic [CMD_W-1:0] op, logic signed [DATA_W-1:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd   <= op;
    cmd_ch.value <= word;
    forever begin
      @(posedge clk);
      if (cmd_ch.ready) break;
    end
    apply_stack_command(op, word);
  endtask

  task automatic hold_until_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return -1;
      4, 5:    return DATA_W'($urandom_range(0, 3)); // small set breeds duplicates
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_search_word();
    if (shadow_fill != 0 && $urandom_range(0, 2) != 0)
      return shadow_words[$urandom_range(0, shadow_fill - 1)];
    return pick_word();
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(bit filling);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 55) return CMD_PUSH;
      if (r < 70) return CMD_POP;
      if (r < 77) return CMD_PEEK;
      if (r < 84) return CMD_DISPLAY;
      if (r < 96) return CMD_SEARCH;
    end else begin
      if (r < 20) return CMD_PUSH;
      if (r < 60) return CMD_POP;
      if (r < 68) return CMD_PEEK;
      if (r < 76) return CMD_DISPLAY;
      if (r < 95) return CMD_SEARCH;
    end
    return CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
  endfunction

  task automatic test_empty_stack();
    send_stack_beat(CMD_POP, WORD_MAX);
    send_stack_beat(CMD_PEEK, '0);
    send_stack_beat(CMD_DISPLAY, '0);
    send_stack_beat(CMD_SEARCH, '0);
    send_stack_beat(CMD_UNUSED_FIRST, WORD_MIN);
    send_stack_beat(CMD_UNUSED_LAST, -1);
  endtask

  task automatic test_fill_and_overflow();
    logic signed [DATA_W-1:0] fill_words [STACK_DEPTH] = '{
      WORD_MIN, WORD_MAX, 32'sd0, -32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sd7, 32'sd1,
      32'sd2, 32'sd7, 32'sh0000_ffff, 32'shffff_0000, 32'sd3, 32'sd7, 32'sd4, 32'sd5};
    int unsigned idx;
    for (idx = 0; idx < STACK_DEPTH; idx++) send_stack_beat(CMD_PUSH, fill_words[idx]);
    send_stack_beat(CMD_PUSH, $urandom);
    send_stack_beat(CMD_DISPLAY, '0);
    send_stack_beat(CMD_SEARCH, 32'sd7);
    send_stack_beat(CMD_SEARCH, WORD_MIN);
    send_stack_beat(CMD_SEARCH, 32'sd6);
  endtask

  // Alternates fill-biased and drain-biased stretches so the stack swings
  // between empty and full.
  task automatic test_random_traffic(int unsigned count);
    int unsigned              idx;
    int unsigned              phase_left;
    bit                       filling;
    logic [CMD_W-1:0]         op;
    logic signed [DATA_W-1:0] word;
    phase_left = 0;
    filling    = 1'b0;
    for (idx = 0; idx < count; idx++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(10, 30);
      end
      phase_left--;
      if (idx == count / 2) hold_until_drained();
      op   = pick_command(filling);
      word = (op == CMD_SEARCH) ? pick_search_word() : pick_word();
      send_stack_beat(op, word);
    end
  endtask

  // Result monitor and receiver stall pattern: quiet stretches alternate with
  // busy ones in which ready drops at random.
  always @(posedge clk) begin : result_monitor
    stack_result_t want;
    bit            next_ready;
    int unsigned   phase_left;
    int unsigned   hold_left;
    bit            busy_phase;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: status %0d data %0d",
               result_ch.status, result_ch.data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_ch.status);
          mismatches++;
        end
        if (result_ch.data !== want.data) begin
          $error("data: expected %0d, got %0d", want.data, result_ch.data);
          mismatches++;
        end
        if (result_ch.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, result_ch.position);
          mismatches++;
        end
        if (result_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, result_ch.last);
          mismatches++;
        end
      end
    end
    if (phase_left == 0) begin
      busy_phase = !busy_phase;
      phase_left = $urandom_range(20, 80);
    end else begin
      phase_left--;
    end
    if (!busy_phase) begin
      next_ready = 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      hold_left  = $urandom_range(0, 6);
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    result_ch.ready <= next_ready;
  end

  initial begin : stimulus
    rst_n           <= 1'b0;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.cmd      <= CMD_PUSH;
    cmd_ch.value    <= '0;
    shadow_fill = 0;
    mismatches  = 0;
    cycle_count = 0;
    burst_left  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_stack();
    test_fill_and_overflow();
    test_random_traffic(125);
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_TIME) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
